### sv/shelf_rectangle_allocator_top_macros.svh
// assertion shorthands used by the allocator core
`ifndef SHELF_RECTANGLE_ALLOCATOR_TOP_MACROS_SVH
`define SHELF_RECTANGLE_ALLOCATOR_TOP_MACROS_SVH

// same-cycle implication
`define SRA_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SRA_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/sra_pkg.sv
package sra_pkg;

	localparam int ALU_W  = 17;
	localparam int NEED_W = 15;

	localparam logic [13:0] INITIAL_EDGE_RST = 14'd256;
	localparam logic [13:0] MAX_EDGE_RST     = 14'd4096;
	localparam logic [7:0]  PAD_RST          = 8'd1;

	typedef enum logic {
		CMD_RESERVE = 1'b0,
		CMD_CLEAR   = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		CFG_INITIAL_EDGE = 2'd0,
		CFG_MAX_EDGE     = 2'd1,
		CFG_PAD          = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		cmd_t        cmd;
		logic [13:0] rect_w;
		logic [13:0] rect_h;
	} in_item_t;

	typedef struct packed {
		logic        ok;
		logic [13:0] pos_x;
		logic [13:0] pos_y;
		logic [13:0] atlas_w;
		logic [13:0] atlas_h;
		logic        grew;
	} out_item_t;

	typedef struct packed {
		logic [13:0] initial_edge;
		logic [13:0] max_edge;
		logic [7:0]  pad;
	} cfg_t;

	typedef struct packed {
		logic [ALU_W-1:0] a;
		logic [ALU_W-1:0] b;
		logic [ALU_W-1:0] c;
		logic [ALU_W-1:0] d;
	} alu_req_t;

	typedef struct packed {
		logic [ALU_W-1:0] sum;
		logic             gt;
	} alu_rsp_t;

endpackage

### sv/sra_alu.sv
module sra_alu
	import sra_pkg::*;
(
	input  alu_req_t op,
	output alu_rsp_t res
);

	always_comb begin
		res.sum = op.a + op.b + op.c;
		res.gt  = res.sum > op.d;
	end

endmodule

### sv/sra_core.sv
`include "shelf_rectangle_allocator_top_macros.svh"

module sra_core
	import sra_pkg::*;
#(
	parameter int EDGE_LIMIT = 8192
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      req_valid,
	output logic      req_stall,
	input  in_item_t  req,
	input  logic      rsp_free,
	output logic      rsp_load,
	output out_item_t rsp_item
);

	localparam int EW = $clog2(EDGE_LIMIT + 1);
	localparam int MW = (EW + 1 > NEED_W) ? EW + 1 : NEED_W;
	localparam int RST_EDGE = (int'(INITIAL_EDGE_RST) > EDGE_LIMIT) ?
		EDGE_LIMIT : int'(INITIAL_EDGE_RST);

	typedef enum logic [7:0] {
		ST_IDLE     = 8'b0000_0001,
		ST_FIT_W    = 8'b0000_0010,
		ST_FIT_H    = 8'b0000_0100,
		ST_WRAP_CHK = 8'b0000_1000,
		ST_WRAP     = 8'b0001_0000,
		ST_ROW_CHK  = 8'b0010_0000,
		ST_PLACE    = 8'b0100_0000,
		ST_GROW     = 8'b1000_0000
	} state_t;

	state_t state_q;
	logic   done_q;

	logic [EW-1:0] cur_w_q, cur_h_q, w0_q, h0_q;
	logic [15:0]   col_q, row_q, px_q, py_q;
	logic [13:0]   shelf_q, w_q, h_q;
	logic [NEED_W-1:0] need_w_q;
	logic          gt_w_q;
	logic [MW-1:0] min_w_q, min_h_q, nw_q, nh_q;
	logic          ok_q, grew_en_q;

	alu_req_t alu_op;
	alu_rsp_t alu_res;

	logic [EW-1:0] eff_init, lim;
	logic [MW-1:0] lim_m, cur_w2, cur_h2, base_w, base_h, need_h;
	logic          accept, grow_w, grow_h, grow_done, grow_fail;

	sra_alu u_alu (
		.op  (alu_op),
		.res (alu_res)
	);

	always_comb begin
		if (cfg.initial_edge == '0) begin
			eff_init = EW'(1);
		end else if (ALU_W'(cfg.initial_edge) > ALU_W'(EDGE_LIMIT)) begin
			eff_init = EW'(EDGE_LIMIT);
		end else begin
			eff_init = EW'(cfg.initial_edge);
		end
		if (ALU_W'(cfg.max_edge) > ALU_W'(EDGE_LIMIT)) begin
			lim = EW'(EDGE_LIMIT);
		end else begin
			lim = EW'(cfg.max_edge);
		end
	end

	always_comb begin
		lim_m     = MW'(lim);
		cur_w2    = MW'({cur_w_q, 1'b0});
		cur_h2    = MW'({cur_h_q, 1'b0});
		base_w    = (cur_w_q == '0) ? MW'(1) : MW'(cur_w_q);
		base_h    = (cur_h_q == '0) ? MW'(1) : MW'(cur_h_q);
		need_h    = MW'(alu_res.sum);
		grow_w    = (nw_q < min_w_q) && (nw_q < lim_m);
		grow_h    = (nh_q < min_h_q) && (nh_q < lim_m);
		grow_done = !grow_w && !grow_h;
		grow_fail = (nw_q == MW'(cur_w_q) && nh_q == MW'(cur_h_q)) ||
			nw_q > lim_m || nh_q > lim_m;
	end

	// operand routing into the shared adder and comparator
	always_comb begin
		alu_op = '0;
		case (state_q)
			ST_FIT_W: begin
				alu_op.a = ALU_W'(w_q);
				alu_op.b = ALU_W'(cfg.pad);
				alu_op.c = ALU_W'(cfg.pad);
				alu_op.d = ALU_W'(cur_w_q);
			end
			ST_FIT_H: begin
				alu_op.a = ALU_W'(h_q);
				alu_op.b = ALU_W'(cfg.pad);
				alu_op.c = ALU_W'(cfg.pad);
				alu_op.d = ALU_W'(cur_h_q);
			end
			ST_WRAP_CHK: begin
				alu_op.a = ALU_W'(col_q);
				alu_op.b = ALU_W'(w_q);
				alu_op.c = ALU_W'(cfg.pad);
				alu_op.d = ALU_W'(cur_w_q);
			end
			ST_WRAP: begin
				alu_op.a = ALU_W'(row_q);
				alu_op.b = ALU_W'(shelf_q);
				alu_op.c = ALU_W'(cfg.pad);
			end
			ST_ROW_CHK: begin
				alu_op.a = ALU_W'(row_q);
				alu_op.b = ALU_W'(h_q);
				alu_op.c = ALU_W'(cfg.pad);
				alu_op.d = ALU_W'(cur_h_q);
			end
			ST_PLACE: begin
				alu_op.a = ALU_W'(col_q);
				alu_op.b = ALU_W'(w_q);
				alu_op.c = ALU_W'(cfg.pad);
			end
			default: begin
				alu_op = '0;
			end
		endcase
	end

	assign req_stall = (state_q != ST_IDLE) || done_q;
	assign accept    = req_valid && !req_stall;
	assign rsp_load  = done_q && rsp_free;

	always_comb begin
		rsp_item.ok      = ok_q;
		rsp_item.pos_x   = 14'(px_q);
		rsp_item.pos_y   = 14'(py_q);
		rsp_item.atlas_w = 14'(cur_w_q);
		rsp_item.atlas_h = 14'(cur_h_q);
		rsp_item.grew    = grew_en_q && (cur_w_q != w0_q || cur_h_q != h0_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			done_q    <= 1'b0;
			cur_w_q   <= EW'(RST_EDGE);
			cur_h_q   <= EW'(RST_EDGE);
			col_q     <= 16'(PAD_RST);
			row_q     <= 16'(PAD_RST);
			shelf_q   <= '0;
			ok_q      <= 1'b1;
			grew_en_q <= 1'b0;
			px_q      <= '0;
			py_q      <= '0;
			min_w_q   <= '0;
			min_h_q   <= '0;
			nw_q      <= '0;
			nh_q      <= '0;
		end else begin
			if (rsp_load) begin
				done_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						ok_q      <= 1'b1;
						px_q      <= '0;
						py_q      <= '0;
						grew_en_q <= 1'b0;
						if (req.cmd == CMD_CLEAR) begin
							cur_w_q <= eff_init;
							cur_h_q <= eff_init;
							col_q   <= 16'(cfg.pad);
							row_q   <= 16'(cfg.pad);
							shelf_q <= '0;
							done_q  <= 1'b1;
						end else if (req.rect_w == '0 || req.rect_h == '0) begin
							done_q <= 1'b1;
						end else begin
							grew_en_q <= 1'b1;
							if (col_q < 16'(cfg.pad)) begin
								col_q <= 16'(cfg.pad);
							end
							if (row_q < 16'(cfg.pad)) begin
								row_q <= 16'(cfg.pad);
							end
							state_q <= ST_FIT_W;
						end
					end
				end
				ST_FIT_W: begin
					state_q <= ST_FIT_H;
				end
				ST_FIT_H: begin
					if (gt_w_q || alu_res.gt) begin
						min_w_q <= (cur_w2 > MW'(need_w_q)) ? cur_w2 : MW'(need_w_q);
						min_h_q <= (cur_h2 > need_h) ? cur_h2 : need_h;
						nw_q    <= base_w;
						nh_q    <= base_h;
						state_q <= ST_GROW;
					end else begin
						state_q <= ST_WRAP_CHK;
					end
				end
				ST_WRAP_CHK: begin
					state_q <= alu_res.gt ? ST_WRAP : ST_ROW_CHK;
				end
				ST_WRAP: begin
					col_q   <= 16'(cfg.pad);
					row_q   <= alu_res.sum[15:0];
					shelf_q <= '0;
					state_q <= ST_ROW_CHK;
				end
				ST_ROW_CHK: begin
					if (alu_res.gt) begin
						min_w_q <= MW'(cur_w_q);
						min_h_q <= cur_h2;
						nw_q    <= base_w;
						nh_q    <= base_h;
						state_q <= ST_GROW;
					end else begin
						state_q <= ST_PLACE;
					end
				end
				ST_PLACE: begin
					px_q    <= col_q;
					py_q    <= row_q;
					col_q   <= alu_res.sum[15:0];
					if (h_q > shelf_q) begin
						shelf_q <= h_q;
					end
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_GROW: begin
					if (grow_w) begin
						nw_q <= nw_q << 1;
					end
					if (grow_h) begin
						nh_q <= nh_q << 1;
					end
					if (grow_done) begin
						if (grow_fail) begin
							ok_q    <= 1'b0;
							done_q  <= 1'b1;
							state_q <= ST_IDLE;
						end else begin
							cur_w_q <= EW'(nw_q);
							cur_h_q <= EW'(nh_q);
							state_q <= ST_FIT_W;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// item payload and per-request snapshots
	always_ff @(posedge clk) begin
		if (accept) begin
			w_q  <= req.rect_w;
			h_q  <= req.rect_h;
			w0_q <= cur_w_q;
			h0_q <= cur_h_q;
		end
		if (state_q == ST_FIT_W) begin
			need_w_q <= NEED_W'(alu_res.sum);
			gt_w_q   <= alu_res.gt;
		end
	end

	`SRA_ASSERT_IMP(a_edge_lim, clk, arst_n, 1'b1,
		cur_w_q <= EW'(EDGE_LIMIT) && cur_h_q <= EW'(EDGE_LIMIT), "atlas edge over limit")
	`SRA_ASSERT_NXT(a_grow_mono, clk, arst_n, state_q == ST_GROW,
		cur_w_q >= $past(cur_w_q) && cur_h_q >= $past(cur_h_q), "atlas shrank while growing")
	`SRA_ASSERT_NXT(a_fail_pos, clk, arst_n, state_q == ST_GROW && grow_done && grow_fail,
		!ok_q && px_q == '0 && py_q == '0 && done_q, "failed request not reported at origin")
	`SRA_ASSERT_IMP(a_place_fit, clk, arst_n, state_q == ST_PLACE,
		ALU_W'(row_q) + ALU_W'(h_q) <= ALU_W'(cur_h_q), "placement below atlas bottom")

endmodule

### sv/shelf_rectangle_allocator_top.sv
// channel  | signals                                  | direction
// req      | req_valid, req_stall, req                | in, stall out
// rsp      | rsp_valid, rsp_stall, rsp                | out, stall in
// cfg      | cfg_valid, cfg_ready, cfg_index, cfg_data | in, ready out
//
// clear and zero-size requests set done_q at transfer, then load the result register once it is free
// placement: FIT_W, FIT_H, WRAP_CHK, WRAP on shelf wrap, ROW_CHK, PLACE; shared adder/compare
// each growth round doubles the short axes in ST_GROW, then retries the fit or reports failure
// arst_n resets the sequencer, atlas size, shelf cursor and config registers
// one result register; the next request transfers while a result waits on rsp_stall
module shelf_rectangle_allocator_top
	import sra_pkg::*;
#(
	parameter int EDGE_LIMIT = 8192
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  in_item_t    req,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output out_item_t   rsp,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [13:0] cfg_data
);

	cfg_t      cfg_q;
	logic      rsp_valid_q;
	out_item_t rsp_q;
	logic      rsp_free, rsp_load;
	out_item_t rsp_item;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.initial_edge <= INITIAL_EDGE_RST;
			cfg_q.max_edge     <= MAX_EDGE_RST;
			cfg_q.pad          <= PAD_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_INITIAL_EDGE: cfg_q.initial_edge <= cfg_data;
				CFG_MAX_EDGE:     cfg_q.max_edge     <= cfg_data;
				CFG_PAD:          cfg_q.pad          <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	sra_core #(
		.EDGE_LIMIT (EDGE_LIMIT)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_free  (rsp_free),
		.rsp_load  (rsp_load),
		.rsp_item  (rsp_item)
	);

	assign rsp_free = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q <= rsp_item;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

### bench/tb_shelf_rectangle_allocator_top.sv
module tb_shelf_rectangle_allocator_top;
	timeunit 1ns;
	timeprecision 1ps;

	import sra_pkg::*;

	localparam int EDGE_LIMIT = 8192;
	localparam logic [1:0] CFG_SPARE = 2'd3;

	class atlas_scoreboard;
		logic [13:0] initial_edge;
		logic [13:0] max_edge;
		logic [7:0]  pad;
		logic [13:0] cur_w;
		logic [13:0] cur_h;
		logic [15:0] col;
		logic [15:0] row;
		logic [13:0] shelf_h;
		out_item_t   placements[$];
		int          errors;

		function new();
			initial_edge = INITIAL_EDGE_RST;
			max_edge     = MAX_EDGE_RST;
			pad          = PAD_RST;
			errors       = 0;
			empty_atlas();
		endfunction

		function void empty_atlas();
			int unsigned e;
			e = 32'(initial_edge);
			if (e < 1) e = 1;
			if (e > EDGE_LIMIT) e = EDGE_LIMIT;
			cur_w   = 14'(e);
			cur_h   = 14'(e);
			col     = 16'(pad);
			row     = 16'(pad);
			shelf_h = '0;
		endfunction

		function void set_reg(logic [1:0] index, logic [13:0] data);
			case (index)
				CFG_INITIAL_EDGE: initial_edge = data;
				CFG_MAX_EDGE:     max_edge = data;
				CFG_PAD:          pad = data[7:0];
				default: ;
			endcase
		endfunction

		// double each axis toward its minimum, never past the growth limit
		function bit try_double(int unsigned min_w, int unsigned min_h);
			int unsigned lim, nw, nh;
			lim = (max_edge > EDGE_LIMIT) ? EDGE_LIMIT : 32'(max_edge);
			nw = (cur_w == 0) ? 1 : 32'(cur_w);
			nh = (cur_h == 0) ? 1 : 32'(cur_h);
			while (nw < min_w && nw < lim) nw = nw * 2;
			while (nh < min_h && nh < lim) nh = nh * 2;
			if (nw == cur_w && nh == cur_h) return 1'b0;
			if (nw > lim || nh > lim) return 1'b0;
			cur_w = 14'(nw);
			cur_h = 14'(nh);
			return 1'b1;
		endfunction

		function void note_request(in_item_t it);
			int unsigned w, h, w0, h0, need_w, need_h;
			bit done;
			out_item_t want;
			w = 32'(it.rect_w);
			h = 32'(it.rect_h);
			want = '0;
			want.ok = 1'b1;
			if (it.cmd == CMD_CLEAR) begin
				empty_atlas();
			end else if (w != 0 && h != 0) begin
				w0 = 32'(cur_w);
				h0 = 32'(cur_h);
				if (col < pad) col = 16'(pad);
				if (row < pad) row = 16'(pad);
				need_w = w + 2 * pad;
				need_h = h + 2 * pad;
				done = 1'b0;
				while (!done) begin
					if (need_w > cur_w || need_h > cur_h) begin
						if (!try_double((cur_w * 2 > need_w) ? cur_w * 2 : need_w,
								(cur_h * 2 > need_h) ? cur_h * 2 : need_h)) begin
							want.ok = 1'b0;
							done = 1'b1;
						end
					end else begin
						// shelf wrap
						if (col + w + pad > cur_w) begin
							col = 16'(pad);
							row = row + shelf_h + pad;
							shelf_h = '0;
						end
						if (row + h + pad > cur_h) begin
							if (!try_double(32'(cur_w), 32'(cur_h) * 2)) begin
								want.ok = 1'b0;
								done = 1'b1;
							end
						end else begin
							want.pos_x = col[13:0];
							want.pos_y = row[13:0];
							col = 16'(col + w + pad);
							if (h > shelf_h) shelf_h = 14'(h);
							done = 1'b1;
						end
					end
				end
				want.grew = (cur_w != w0 || cur_h != h0);
			end
			want.atlas_w = cur_w;
			want.atlas_h = cur_h;
			placements.push_back(want);
		endfunction

		task log_mismatch(string msg);
			$display("mismatch: %s", msg);
			errors++;
		endtask

		task check_result(out_item_t got);
			out_item_t want;
			if (placements.size() == 0) begin
				log_mismatch($sformatf("result with nothing outstanding: %p", got));
			end else begin
				want = placements.pop_front();
				if (got.ok !== want.ok)
					log_mismatch($sformatf("ok %b, expected %b", got.ok, want.ok));
				if (got.pos_x !== want.pos_x)
					log_mismatch($sformatf("pos_x %0d, expected %0d", got.pos_x, want.pos_x));
				if (got.pos_y !== want.pos_y)
					log_mismatch($sformatf("pos_y %0d, expected %0d", got.pos_y, want.pos_y));
				if (got.atlas_w !== want.atlas_w)
					log_mismatch($sformatf("atlas_w %0d, expected %0d",
						got.atlas_w, want.atlas_w));
				if (got.atlas_h !== want.atlas_h)
					log_mismatch($sformatf("atlas_h %0d, expected %0d",
						got.atlas_h, want.atlas_h));
				if (got.grew !== want.grew)
					log_mismatch($sformatf("grew %b, expected %b", got.grew, want.grew));
			end
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	in_item_t    req = '0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	out_item_t   rsp;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [13:0] cfg_data = '0;

	atlas_scoreboard sb;
	bit no_idle = 1'b0;
	int results_seen = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;

	shelf_rectangle_allocator_top #(
		.EDGE_LIMIT(EDGE_LIMIT)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// result side: check every transfer, stall at random unless no_idle is set, one long hold-off
	always @(posedge clk) begin
		if (rsp_valid && !rsp_stall) begin
			sb.check_result(rsp);
			results_seen++;
		end
		if (hold_left != 0) begin
			hold_left--;
			rsp_stall <= 1'b1;
		end else if (!hold_done && results_seen >= 200) begin
			hold_done = 1'b1;
			hold_left = 300;
			rsp_stall <= 1'b1;
		end else if (no_idle) begin
			rsp_stall <= 1'b0;
		end else begin
			rsp_stall <= ($urandom_range(99) < 31);
		end
	end

	task send_item(in_item_t it);
		while (!no_idle && $urandom_range(99) < 31) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= it;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		sb.note_request(it);
	endtask

	task send_rect(cmd_t cmd, int unsigned w, int unsigned h);
		in_item_t it;
		it.cmd = cmd;
		it.rect_w = 14'(w);
		it.rect_h = 14'(h);
		send_item(it);
	endtask

	task wait_drained();
		req_valid <= 1'b0;
		@(posedge clk);
		while (sb.placements.size() != 0) @(posedge clk);
	endtask

	task write_reg(logic [1:0] index, logic [13:0] data);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.set_reg(index, data);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [13:0] pick_side();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 8) return '0;
		if (r < 68) return 14'($urandom_range(32, 1));
		if (r < 83) return 14'($urandom_range(256, 1));
		if (r < 93) return 14'($urandom_range(2048, 1));
		return 14'($urandom_range(EDGE_LIMIT, 0));
	endfunction

	function automatic logic [13:0] pick_edge_reg();
		if ($urandom_range(1)) return 14'd1 << $urandom_range(10, 3);
		return 14'($urandom_range(EDGE_LIMIT, 1));
	endfunction

	task run_random(int count);
		in_item_t it;
		repeat (count) begin
			it.cmd = ($urandom_range(99) < 4) ? CMD_CLEAR : CMD_RESERVE;
			it.rect_w = pick_side();
			it.rect_h = pick_side();
			send_item(it);
		end
	endtask

	initial begin
		#5_000_000;
		$display("tb: failure");
		$finish;
	end

	initial begin
		sb = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// defaults: zero sizes, placement, wrap, growth, failed growth, clear
		send_rect(CMD_RESERVE, 0, 5);
		send_rect(CMD_RESERVE, 7, 0);
		send_rect(CMD_RESERVE, 0, 0);
		send_rect(CMD_RESERVE, 10, 20);
		send_rect(CMD_RESERVE, 200, 30);
		send_rect(CMD_RESERVE, 100, 10);
		send_rect(CMD_RESERVE, 255, 10);
		send_rect(CMD_RESERVE, 8192, 8192);
		send_rect(CMD_CLEAR, 16383, 16383);
		send_rect(CMD_RESERVE, 8191, 1);
		send_rect(CMD_CLEAR, 0, 0);
		send_rect(CMD_RESERVE, 1, 8192);
		send_rect(CMD_CLEAR, 5, 5);
		send_rect(CMD_RESERVE, 100, 200);
		send_rect(CMD_RESERVE, 100, 200);
		send_rect(CMD_RESERVE, 100, 200);
		send_rect(CMD_RESERVE, 1, 1);
		send_rect(CMD_RESERVE, 4000, 3);
		send_rect(CMD_RESERVE, 3, 4000);
		send_rect(CMD_RESERVE, 8191, 8191);

		// smallest atlas, no growth possible
		write_reg(CFG_INITIAL_EDGE, 14'd0);
		write_reg(CFG_MAX_EDGE, 14'd0);
		write_reg(CFG_PAD, 14'd0);
		send_rect(CMD_CLEAR, 0, 0);
		send_rect(CMD_RESERVE, 1, 1);
		send_rect(CMD_RESERVE, 1, 1);
		run_random(40);

		// edges beyond the limit, widest padding
		write_reg(CFG_INITIAL_EDGE, 14'h3FFF);
		write_reg(CFG_MAX_EDGE, 14'h3FFF);
		write_reg(CFG_PAD, 14'h3FFF);
		send_rect(CMD_CLEAR, 0, 0);
		run_random(100);

		// tiny start, full growth range, back to back transfers
		write_reg(CFG_INITIAL_EDGE, 14'd1);
		write_reg(CFG_MAX_EDGE, 14'(EDGE_LIMIT));
		write_reg(CFG_PAD, 14'd0);
		send_rect(CMD_CLEAR, 0, 0);
		no_idle = 1'b1;
		run_random(100);
		no_idle = 1'b0;

		// cursor behind a larger pad, atlas already beyond the growth limit
		write_reg(CFG_PAD, 14'd200);
		write_reg(CFG_MAX_EDGE, 14'd16);
		run_random(30);

		write_reg(CFG_SPARE, 14'($urandom_range(16383)));
		repeat (6) begin
			write_reg(CFG_INITIAL_EDGE, pick_edge_reg());
			write_reg(CFG_MAX_EDGE, pick_edge_reg());
			write_reg(CFG_PAD, {6'($urandom_range(63)),
				8'($urandom_range(1) ? $urandom_range(4) : $urandom_range(255))});
			if ($urandom_range(1)) send_rect(CMD_CLEAR, 0, 0);
			run_random(95);
		end

		wait_drained();
		repeat (30) @(posedge clk);
		if (sb.errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

### files.f
+incdir+sv
sv/sra_pkg.sv
sv/sra_alu.sv
sv/sra_core.sv
sv/shelf_rectangle_allocator_top.sv
bench/tb_shelf_rectangle_allocator_top.sv
